/* sv/hrs_pkg.sv */
// Shared types and constants for the HTTP response header splitter.
// No dependencies; the front, back, top level and testbench import this package.
package hrs_pkg;

  localparam int HEADER_BUFFER_BYTES = 4096;
  localparam int LIMIT_CAP_INT = (HEADER_BUFFER_BYTES - 1 > 4095) ? 4095
                                                                  : HEADER_BUFFER_BYTES - 1;
  localparam logic [11:0] LIMIT_CAP = LIMIT_CAP_INT[11:0];

  localparam int QUEUE_DEPTH = 2;

  localparam logic [11:0] HEADER_LIMIT_RST    = 12'd4095;
  localparam logic [15:0] EXPECTED_STATUS_RST = 16'd200;

  localparam logic CFG_HEADER_LIMIT    = 1'b0;
  localparam logic CFG_EXPECTED_STATUS = 1'b1;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  localparam logic [2:0] TM_NONE    = 3'd0;
  localparam logic [2:0] TM_CR      = 3'd1;
  localparam logic [2:0] TM_CRLF    = 3'd2;
  localparam logic [2:0] TM_CRLFCR  = 3'd3;
  localparam logic [2:0] TM_LF      = 3'd4;

  localparam logic [2:0] PS_WAIT_SP = 3'd0;
  localparam logic [2:0] PS_SKIP_WS = 3'd1;
  localparam logic [2:0] PS_SIGN    = 3'd2;
  localparam logic [2:0] PS_DIGITS  = 3'd3;
  localparam logic [2:0] PS_DONE    = 3'd4;

  localparam logic [2:0] EV_HDR    = 3'd0;
  localparam logic [2:0] EV_BODY   = 3'd1;
  localparam logic [2:0] EV_OK     = 3'd2;
  localparam logic [2:0] EV_BADST  = 3'd3;
  localparam logic [2:0] EV_TOOBIG = 3'd4;
  localparam logic [2:0] EV_EARLY  = 3'd5;
  localparam logic [2:0] EV_DONE   = 3'd6;
  localparam logic [2:0] EV_IGN    = 3'd7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [2:0]  event_res;
    logic [15:0] status_value;
  } hrs_rec_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [2:0]  event_res;
    logic [15:0] status_value;
    logic [31:0] total_bytes;
  } hrs_out_t;

endpackage

/* sv/hrs_fifo.sv */
// Small register queue used between the front and back parts and at the output.
// Depends on nothing but its parameters.
module hrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = DEPTH[CW-1:0];

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slots_r[rd_ptr_r];

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    n = p + 1'b1;
    if (p == AW'(DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* sv/hrs_front.sv */
// Front part: configuration registers, header framing, status parsing, classification.
// Depends on hrs_pkg.
module hrs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output hrs_pkg::hrs_rec_t rec
);
  import hrs_pkg::*;

  logic [11:0] header_limit_r;
  logic [15:0] expected_status_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  term_r, term_nxt;
  logic [11:0] hcount_r, hcount_nxt;
  logic [2:0]  pstep_r, pstep_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic        neg_r, neg_nxt;

  logic [11:0] lim;
  logic        is_ws, is_digit, term_hit;
  logic [19:0] mac;
  logic [2:0]  ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_limit_r    <= HEADER_LIMIT_RST;
      expected_status_r <= EXPECTED_STATUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_LIMIT:    header_limit_r    <= cfg_data[11:0];
        CFG_EXPECTED_STATUS: expected_status_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim      = (header_limit_r < LIMIT_CAP) ? header_limit_r : LIMIT_CAP;
  assign is_ws    = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign mac      = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
                  + {16'd0, data_byte[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    term_nxt  = term_r;
    hcount_nxt = hcount_r;
    pstep_nxt = pstep_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    term_hit  = 1'b0;
    ev        = EV_IGN;

    if (phase_r == PH_HEADER) begin
      if (stream_end) begin
        ev        = EV_EARLY;
        phase_nxt = PH_STOP;
      end else if (hcount_r >= lim) begin
        ev        = EV_TOOBIG;
        phase_nxt = PH_STOP;
      end else begin
        hcount_nxt = hcount_r + 1'b1;
        ev         = EV_HDR;

        unique case (pstep_r)
          PS_WAIT_SP: begin
            if (data_byte == CH_SPACE) begin
              pstep_nxt = PS_SKIP_WS;
            end
          end
          PS_SKIP_WS: begin
            if (!is_ws) begin
              if (data_byte == CH_PLUS) begin
                pstep_nxt = PS_SIGN;
              end else if (data_byte == CH_MINUS) begin
                neg_nxt   = 1'b1;
                pstep_nxt = PS_SIGN;
              end else if (is_digit) begin
                accum_nxt = {12'd0, data_byte[3:0]};
                pstep_nxt = PS_DIGITS;
              end else begin
                pstep_nxt = PS_DONE;
              end
            end
          end
          PS_SIGN, PS_DIGITS: begin
            if (is_digit) begin
              accum_nxt = (mac > 20'd65535) ? 16'hFFFF : mac[15:0];
              pstep_nxt = PS_DIGITS;
            end else begin
              pstep_nxt = PS_DONE;
            end
          end
          default: ;
        endcase

        if (data_byte == CH_CR) begin
          term_nxt = (term_r == TM_CRLF) ? TM_CRLFCR : TM_CR;
        end else if (data_byte == CH_LF) begin
          if (term_r == TM_CRLF || term_r == TM_CRLFCR || term_r == TM_LF) begin
            term_nxt = TM_NONE;
            term_hit = 1'b1;
          end else begin
            term_nxt = (term_r == TM_CR) ? TM_CRLF : TM_LF;
          end
        end else begin
          term_nxt = TM_NONE;
        end

        if (term_hit) begin
          if (!neg_nxt && accum_nxt == expected_status_r) begin
            ev        = EV_OK;
            phase_nxt = PH_BODY;
          end else begin
            ev        = EV_BADST;
            phase_nxt = PH_STOP;
          end
        end
      end
    end else if (phase_r == PH_BODY) begin
      if (stream_end) begin
        ev        = EV_DONE;
        phase_nxt = PH_STOP;
      end else begin
        ev = EV_BODY;
      end
    end
  end

  assign rec.body_byte    = (ev == EV_BODY) ? data_byte : 8'd0;
  assign rec.event_res    = ev;
  assign rec.status_value = accum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      term_r   <= TM_NONE;
      hcount_r <= '0;
      pstep_r  <= PS_WAIT_SP;
      accum_r  <= '0;
      neg_r    <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      term_r   <= term_nxt;
      hcount_r <= hcount_nxt;
      pstep_r  <= pstep_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
    end
  end

endmodule

/* sv/hrs_back.sv */
// Back part: body byte totals and the result queue.
// Depends on hrs_pkg and hrs_fifo.
module hrs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hrs_pkg::hrs_rec_t rec,
  input  logic              rec_valid,
  output logic              rec_take,
  input  logic              out_pop,
  output logic              out_empty,
  output hrs_pkg::hrs_out_t res
);
  import hrs_pkg::*;

  logic [31:0] total_r, total_nxt;
  logic        q_full;
  hrs_out_t    q_in;
  logic [$bits(hrs_out_t)-1:0] q_out;

  assign rec_take  = rec_valid & ~q_full;
  assign total_nxt = (rec.event_res == EV_BODY && total_r != 32'hFFFF_FFFF)
                   ? total_r + 32'd1 : total_r;

  assign q_in.body_byte    = rec.body_byte;
  assign q_in.event_res    = rec.event_res;
  assign q_in.status_value = rec.status_value;
  assign q_in.total_bytes  = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (rec_take) begin
      total_r <= total_nxt;
    end
  end

  hrs_fifo #(
    .WIDTH ($bits(hrs_out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_take),
    .push_data (q_in),
    .full      (q_full),
    .pop       (out_pop),
    .pop_data  (q_out),
    .empty     (out_empty)
  );

  assign res = hrs_out_t'(q_out);

endmodule

/* sv/http_response_header_splitter.sv */
// Top level of the HTTP response header splitter: front, decoupling queue, back.
// Depends on hrs_pkg, hrs_front, hrs_fifo and hrs_back.
//
//   Channel  Ports                                   Transfer when
//   input    in_data_byte, in_stream_end             in_push & !in_full
//   result   out_body_byte, out_event_res,           out_pop & !out_empty
//            out_status_value, out_total_bytes
//   config   cfg_we, cfg_index, cfg_data             cfg_we
//
// One byte per cycle sustained while the output is not stalled; each input yields one result.
// From input transfer to the ports, a result passes through the front-to-back queue
// and then the output queue (two entries each).
// A stalled output fills the output queue, then the middle queue, then raises in_full.
// Reset (synchronous, rst_n low) returns to header phase with registers at defaults.
module http_response_header_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_body_byte,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_status_value,
  output logic [31:0] out_total_bytes
);
  import hrs_pkg::*;

  hrs_rec_t front_rec;
  logic [$bits(hrs_rec_t)-1:0] mid_out;
  logic     mid_empty, mid_take, in_take;
  hrs_out_t res;

  assign in_take = in_push & ~in_full;

  hrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (in_take),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .rec        (front_rec)
  );

  hrs_fifo #(
    .WIDTH ($bits(hrs_rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_midq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_rec),
    .full      (in_full),
    .pop       (mid_take),
    .pop_data  (mid_out),
    .empty     (mid_empty)
  );

  hrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (hrs_rec_t'(mid_out)),
    .rec_valid (~mid_empty),
    .rec_take  (mid_take),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_body_byte    = res.body_byte;
  assign out_event_res    = res.event_res;
  assign out_status_value = res.status_value;
  assign out_total_bytes  = res.total_bytes;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_response_header_splitter: one response stream with a
// directed status line, random header and body bytes, register writes and output stalls.
// Depends on hrs_pkg and the RTL of the block; predicts every result from its own model.
module testbench;
  import hrs_pkg::*;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       closed;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_HEADER_LIMIT;
  logic [15:0] cfg_data = 16'd0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_end = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_body_byte;
  logic [2:0]  out_event_res;
  logic [15:0] out_status_value;
  logic [31:0] out_total_bytes;

  stream_item_t tx_bytes[$];
  stream_item_t sent_item;
  hrs_out_t     expected_results[$];
  hrs_out_t     want;
  int           mismatches = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  logic         calm = 1'b0;
  logic         stall_req = 1'b0;
  logic         recv_hold = 1'b0;

  logic [1:0]  phase_q;
  logic [2:0]  term_q;
  logic [11:0] hdr_count;
  logic [2:0]  parse_q;
  logic [15:0] status_acc;
  logic        status_neg;
  logic [31:0] body_count;
  logic [11:0] limit_reg;
  logic [15:0] want_status;
  logic [2:0]  gen_term;

  http_response_header_splitter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_stream_end(in_stream_end),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_body_byte(out_body_byte), .out_event_res(out_event_res),
    .out_status_value(out_status_value), .out_total_bytes(out_total_bytes)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [2:0] term_step(input logic [2:0] m, input logic [7:0] c,
                                           output logic hit);
    hit = 1'b0;
    if (c == CH_CR) return (m == TM_CRLF) ? TM_CRLFCR : TM_CR;
    if (c == CH_LF) begin
      if (m == TM_CRLF || m == TM_CRLFCR || m == TM_LF) begin
        hit = 1'b1;
        return TM_NONE;
      end
      return (m == TM_CR) ? TM_CRLF : TM_LF;
    end
    return TM_NONE;
  endfunction

  task automatic split_byte(input logic [7:0] c, input logic closed);
    hrs_out_t r;
    logic     hit;
    logic     digit;
    int       lim;
    int       v;
    r = '0;
    r.event_res = EV_IGN;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (phase_q == PH_HEADER) begin
      lim = (int'(limit_reg) > HEADER_BUFFER_BYTES - 1) ? HEADER_BUFFER_BYTES - 1
                                                         : int'(limit_reg);
      if (closed) begin
        r.event_res = EV_EARLY;
        phase_q = PH_STOP;
      end else if (int'(hdr_count) + 1 > lim) begin
        r.event_res = EV_TOOBIG;
        phase_q = PH_STOP;
      end else begin
        hdr_count = hdr_count + 12'd1;
        case (parse_q)
          PS_WAIT_SP: if (c == CH_SPACE) parse_q = PS_SKIP_WS;
          PS_SKIP_WS: begin
            if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
              if (c == CH_PLUS) begin
                parse_q = PS_SIGN;
              end else if (c == CH_MINUS) begin
                status_neg = 1'b1;
                parse_q = PS_SIGN;
              end else if (digit) begin
                status_acc = 16'(c - CH_ZERO);
                parse_q = PS_DIGITS;
              end else begin
                parse_q = PS_DONE;
              end
            end
          end
          PS_SIGN, PS_DIGITS: begin
            if (digit) begin
              v = int'(status_acc) * 10 + int'(c - CH_ZERO);
              status_acc = (v > 65535) ? 16'hFFFF : 16'(v);
              parse_q = PS_DIGITS;
            end else begin
              parse_q = PS_DONE;
            end
          end
          default: ;
        endcase
        r.event_res = EV_HDR;
        term_q = term_step(term_q, c, hit);
        if (hit) begin
          if (!status_neg && status_acc == want_status) begin
            r.event_res = EV_OK;
            phase_q = PH_BODY;
          end else begin
            r.event_res = EV_BADST;
            phase_q = PH_STOP;
          end
        end
      end
    end else if (phase_q == PH_BODY) begin
      if (closed) begin
        r.event_res = EV_DONE;
        phase_q = PH_STOP;
      end else begin
        r.event_res = EV_BODY;
        r.body_byte = c;
        if (body_count != 32'hFFFF_FFFF) body_count = body_count + 32'd1;
      end
    end
    r.status_value = status_acc;
    r.total_bytes = body_count;
    expected_results.push_back(r);
  endtask

  task automatic add_item(input logic [7:0] c, input logic closed);
    stream_item_t it;
    it.byte_val = c;
    it.closed = closed;
    tx_bytes.push_back(it);
  endtask

  // Replace any byte that would end the header early.
  task automatic add_hdr(input logic [7:0] c);
    logic       hit;
    logic [2:0] nxt;
    nxt = term_step(gen_term, c, hit);
    if (hit) begin
      c = 8'h61;
      nxt = TM_NONE;
    end
    gen_term = nxt;
    add_item(c, 1'b0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEADER_LIMIT) limit_reg = val[11:0];
    else want_status = val;
  endtask

  task automatic wait_drained;
    while (tx_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_push <= 1'b0;
    end else if (tx_bytes.size() == 0) begin
      in_push <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 4);
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_data_byte <= tx_bytes[0].byte_val;
      in_stream_end <= tx_bytes[0].closed;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      split_byte(in_data_byte, in_stream_end);
      sent_item = tx_bytes.pop_front();
    end
  end

  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      out_pop <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 4);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: event %0d byte %02h status %0d total %0d",
                   out_event_res, out_body_byte, out_status_value, out_total_bytes);
      end else begin
        want = expected_results.pop_front();
        if (out_body_byte !== want.body_byte || out_event_res !== want.event_res ||
            out_status_value !== want.status_value ||
            out_total_bytes !== want.total_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected ev %0d byte %02h status %0d total %0d,",
                      " got ev %0d byte %02h status %0d total %0d"},
                     $time, want.event_res, want.body_byte, want.status_value,
                     want.total_bytes, out_event_res, out_body_byte, out_status_value,
                     out_total_bytes);
        end
      end
    end
  end

  // Hold off the receiver long enough to back up the input.
  initial begin
    wait (stall_req);
    recv_hold = 1'b1;
    repeat (64) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int pick;
    logic [7:0] c;
    phase_q = PH_HEADER;
    term_q = TM_NONE;
    hdr_count = 12'd0;
    parse_q = PS_WAIT_SP;
    status_acc = 16'd0;
    status_neg = 1'b0;
    body_count = 32'd0;
    limit_reg = HEADER_LIMIT_RST;
    want_status = EXPECTED_STATUS_RST;
    gen_term = TM_NONE;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_HEADER_LIMIT, 16'd4095);
    write_reg(CFG_EXPECTED_STATUS, 16'hFFFF);

    // Status line: whitespace skip, plus sign, saturation, then partial terminators.
    add_hdr(8'h48); add_hdr(8'h00); add_hdr(8'hFF); add_hdr(CH_SPACE); add_hdr(CH_TAB);
    add_hdr(CH_CR); add_hdr(CH_LF); add_hdr(8'h0B); add_hdr(8'h0C); add_hdr(CH_SPACE);
    add_hdr(CH_PLUS); add_hdr(8'h30); add_hdr(8'h36); add_hdr(8'h35); add_hdr(8'h35);
    add_hdr(8'h33); add_hdr(8'h36); add_hdr(CH_NINE); add_hdr(8'h78); add_hdr(CH_CR);
    add_hdr(CH_LF); add_hdr(CH_CR); add_hdr(8'h41); add_hdr(CH_LF); add_hdr(8'h42);

    for (int i = 0; i < 500; i++) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) c = CH_CR;
      else if (pick == 1) c = CH_LF;
      else c = 8'($urandom_range(0, 255));
      add_hdr(c);
    end

    add_item(8'h7A, 1'b0);
    if ($urandom_range(0, 1) == 0) begin
      add_item(CH_CR, 1'b0);
      add_item(CH_LF, 1'b0);
      add_item(CH_CR, 1'b0);
      add_item(CH_LF, 1'b0);
    end else begin
      add_item(CH_LF, 1'b0);
      add_item(CH_LF, 1'b0);
    end
    wait_drained;

    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 200; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
      if (k == 1) stall_req = 1'b1;
      wait_drained;
      case (k)
        0: begin
          write_reg(CFG_HEADER_LIMIT, 16'd0);
          write_reg(CFG_EXPECTED_STATUS, 16'd0);
        end
        1: begin
          write_reg(CFG_HEADER_LIMIT, 16'd1);
          write_reg(CFG_EXPECTED_STATUS, 16'($urandom_range(0, 65535)));
        end
        2: write_reg(CFG_HEADER_LIMIT, 16'($urandom_range(1, 4095)));
        default: write_reg(CFG_EXPECTED_STATUS, 16'd200);
      endcase
    end

    calm = 1'b1;
    for (int i = 0; i < 100; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
    add_item(8'($urandom_range(0, 255)), 1'b1);
    for (int i = 0; i < 5; i++)
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    while (tx_bytes.size() != 0) @(posedge clk);
    wait_drained;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
